// File: rtl/gvm_pkg.sv
// Shared constants, widths and helpers for the greedy voxel face mesher.
// Depends on nothing; the mesher top level and its testbench import it.
package gvm_pkg;

    localparam int CHUNK_EXTENT  = 16;  // must be a power of two
    localparam int MATERIAL_BITS = 16;

    localparam int CW  = $clog2(CHUNK_EXTENT);      // one coordinate index
    localparam int CW1 = $clog2(CHUNK_EXTENT + 1);  // a count up to the extent
    localparam int SW  = CW1 + 1;                   // room for a sum of two counts
    localparam int VOX_AW = 3 * CW;
    localparam int MSK_AW = 2 * CW;
    localparam int VOX_DEPTH = CHUNK_EXTENT * CHUNK_EXTENT * CHUNK_EXTENT;
    localparam int MSK_DEPTH = CHUNK_EXTENT * CHUNK_EXTENT;
    localparam int CELL_W = MATERIAL_BITS + 1;

    localparam int COORD_IN_W = 4;
    localparam int MAT_IN_W   = 16;
    localparam int ORG_W      = 5;
    localparam int EXT_W      = 5;

    localparam logic       OP_WRITE = 1'b0;
    localparam logic       OP_FETCH = 1'b1;
    localparam logic [1:0] AXIS_X   = 2'd0;
    localparam logic [1:0] AXIS_Y   = 2'd1;
    localparam logic [1:0] AXIS_Z   = 2'd2;

    // Voxel address of the point with coordinate c on the normal axis and
    // u, v on the two in-plane axes.
    function automatic logic [VOX_AW-1:0] vox_addr(
        input logic [1:0]    axis,
        input logic [CW-1:0] c,
        input logic [CW-1:0] u,
        input logic [CW-1:0] v
    );
        logic [VOX_AW-1:0] a;
        unique case (axis)
            AXIS_X:  a = {v, u, c};
            AXIS_Y:  a = {u, c, v};
            default: a = {c, v, u};
        endcase
        return a;
    endfunction

endpackage

// File: rtl/greedy_voxel_face_mesher.sv
// Greedy voxel face mesher top level: sequencer, voxel store and slice mask.
// Depends on gvm_pkg and gvm_ram.

// A write item returns an all-zero result. A fetch item walks the scan until
// it finds the next quad or reaches the end of the scan, and is not accepted
// alongside anything else. Building the mask of a slice takes, per cell, two
// voxel store reads and one mask write. The scan visits the mask cells row by
// row, grows each quad first along its row by comparing cells and then by
// trying further rows, and clears its cells. A fetch that finds no face
// crosses all 51 slices of the three axes, 17 per axis. Writes and register
// writes restart the traversal.
module greedy_voxel_face_mesher (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [15:0]                     cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_opcode,
    input  logic [gvm_pkg::COORD_IN_W-1:0]  s_voxel_x,
    input  logic [gvm_pkg::COORD_IN_W-1:0]  s_voxel_y,
    input  logic [gvm_pkg::COORD_IN_W-1:0]  s_voxel_z,
    input  logic [gvm_pkg::MAT_IN_W-1:0]    s_material,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_quad_valid,
    output logic                            m_scan_done,
    output logic [1:0]                      m_face_axis,
    output logic                            m_normal_positive,
    output logic [gvm_pkg::ORG_W-1:0]       m_origin_x,
    output logic [gvm_pkg::ORG_W-1:0]       m_origin_y,
    output logic [gvm_pkg::ORG_W-1:0]       m_origin_z,
    output logic [gvm_pkg::EXT_W-1:0]       m_extent_u,
    output logic [gvm_pkg::EXT_W-1:0]       m_extent_v,
    output logic [gvm_pkg::MAT_IN_W-1:0]    m_face_material
);
    import gvm_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_BLD_A  = 4'd1;
    localparam logic [3:0] ST_BLD_B  = 4'd2;
    localparam logic [3:0] ST_BLD_C  = 4'd3;
    localparam logic [3:0] ST_SCAN   = 4'd4;
    localparam logic [3:0] ST_SCHK   = 4'd5;
    localparam logic [3:0] ST_GU     = 4'd6;
    localparam logic [3:0] ST_GU_CHK = 4'd7;
    localparam logic [3:0] ST_GV     = 4'd8;
    localparam logic [3:0] ST_GV_RD  = 4'd9;
    localparam logic [3:0] ST_GV_CHK = 4'd10;
    localparam logic [3:0] ST_CLR    = 4'd11;
    localparam logic [3:0] ST_OUT    = 4'd12;

    localparam logic [CW1-1:0] EXT_C = CW1'(CHUNK_EXTENT);
    localparam logic [SW-1:0]  EXT_S = SW'(CHUNK_EXTENT);

    logic [3:0]               state_reg;
    logic [MATERIAL_BITS-1:0] empty_reg;
    logic [1:0]               axis_reg;
    logic [CW1-1:0]           sl1_reg;   // slice index plus one
    logic [CW1-1:0]           row_reg;
    logic [CW1-1:0]           col_reg;
    logic                     built_reg;
    logic                     fin_reg;
    logic [MSK_AW-1:0]        cnt_reg;
    logic [MATERIAL_BITS-1:0] cur_reg;
    logic [MATERIAL_BITS-1:0] cmat_reg;
    logic                     cpos_reg;
    logic [CW1-1:0]           w_reg;
    logic [CW1-1:0]           h_reg;
    logic [CW-1:0]            a_reg;
    logic [CW-1:0]            b_reg;

    logic                     m_valid_reg;
    logic                     q_valid_reg;
    logic                     done_reg;
    logic [1:0]               f_axis_reg;
    logic                     f_pos_reg;
    logic [ORG_W-1:0]         ox_reg;
    logic [ORG_W-1:0]         oy_reg;
    logic [ORG_W-1:0]         oz_reg;
    logic [EXT_W-1:0]         eu_reg;
    logic [EXT_W-1:0]         ev_reg;
    logic [MAT_IN_W-1:0]      fmat_reg;

    logic                     vox_we;
    logic [VOX_AW-1:0]        vox_waddr;
    logic [VOX_AW-1:0]        vox_raddr;
    logic [MATERIAL_BITS-1:0] vox_rdata;
    logic                     msk_we;
    logic [MSK_AW-1:0]        msk_waddr;
    logic [CELL_W-1:0]        msk_wdata;
    logic [MSK_AW-1:0]        msk_raddr;
    logic [CELL_W-1:0]        msk_rdata;

    logic                     accept;
    logic                     wr_in_range;
    logic                     cur_in;
    logic                     adj_in;
    logic [CW-1:0]            cell_u;
    logic [CW-1:0]            cell_v;
    logic [SW-1:0]            uw_sum;
    logic [SW-1:0]            vh_sum;
    logic [SW-1:0]            ua_sum;
    logic [MATERIAL_BITS-1:0] adj_mat;
    logic                     cur_solid;
    logic                     adj_solid;
    logic                     cell_same;

    assign s_ready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign accept  = s_valid && s_ready;

    assign wr_in_range = ({1'b0, s_voxel_x} < EXT_S[COORD_IN_W:0])
                      && ({1'b0, s_voxel_y} < EXT_S[COORD_IN_W:0])
                      && ({1'b0, s_voxel_z} < EXT_S[COORD_IN_W:0]);

    assign cur_in = (sl1_reg != '0);
    assign adj_in = (sl1_reg != EXT_C);
    assign cell_u = cnt_reg[CW-1:0];
    assign cell_v = cnt_reg[MSK_AW-1:CW];
    assign uw_sum = {1'b0, col_reg} + {1'b0, w_reg};
    assign vh_sum = {1'b0, row_reg} + {1'b0, h_reg};
    assign ua_sum = {1'b0, col_reg} + SW'(a_reg);

    assign adj_mat   = adj_in ? vox_rdata : empty_reg;
    assign cur_solid = (cur_reg != empty_reg);
    assign adj_solid = (adj_mat != empty_reg);
    assign cell_same = (msk_rdata == {cmat_reg, cpos_reg});

    assign vox_we    = accept && (s_opcode == OP_WRITE) && wr_in_range;
    assign vox_waddr = {s_voxel_z[CW-1:0], s_voxel_y[CW-1:0], s_voxel_x[CW-1:0]};

    always_comb begin
        if (state_reg == ST_BLD_A) begin
            vox_raddr = vox_addr(axis_reg, CW'(sl1_reg - CW1'(1)), cell_u, cell_v);
        end else begin
            vox_raddr = vox_addr(axis_reg, sl1_reg[CW-1:0], cell_u, cell_v);
        end
    end

    always_comb begin
        unique case (state_reg)
            ST_GU:    msk_raddr = {row_reg[CW-1:0], uw_sum[CW-1:0]};
            ST_GV_RD: msk_raddr = {vh_sum[CW-1:0], ua_sum[CW-1:0]};
            default:  msk_raddr = {row_reg[CW-1:0], col_reg[CW-1:0]};
        endcase
    end

    always_comb begin
        msk_we    = 1'b0;
        msk_waddr = cnt_reg;
        msk_wdata = {empty_reg, 1'b0};
        if (state_reg == ST_BLD_C) begin
            msk_we = 1'b1;
            if (cur_solid != adj_solid) begin
                msk_wdata = {(cur_solid ? cur_reg : adj_mat), cur_solid};
            end
        end else if (state_reg == ST_CLR) begin
            msk_we    = 1'b1;
            msk_waddr = {CW'(row_reg + CW1'(b_reg)), CW'(col_reg + CW1'(a_reg))};
        end
    end

    gvm_ram #(.WIDTH(MATERIAL_BITS), .DEPTH(VOX_DEPTH)) u_vox (
        .aclk    (aclk),
        .wr_en   (vox_we),
        .wr_addr (vox_waddr),
        .wr_data (s_material[MATERIAL_BITS-1:0]),
        .rd_addr (vox_raddr),
        .rd_data (vox_rdata)
    );

    gvm_ram #(.WIDTH(CELL_W), .DEPTH(MSK_DEPTH)) u_mask (
        .aclk    (aclk),
        .wr_en   (msk_we),
        .wr_addr (msk_waddr),
        .wr_data (msk_wdata),
        .rd_addr (msk_raddr),
        .rd_data (msk_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            empty_reg   <= '0;
            axis_reg    <= AXIS_X;
            sl1_reg     <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
            built_reg   <= 1'b0;
            fin_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                empty_reg <= cfg_wr_data[MATERIAL_BITS-1:0];
                axis_reg  <= AXIS_X;
                sl1_reg   <= '0;
                row_reg   <= '0;
                col_reg   <= '0;
                built_reg <= 1'b0;
                fin_reg   <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (s_opcode == OP_WRITE) begin
                            axis_reg    <= AXIS_X;
                            sl1_reg     <= '0;
                            row_reg     <= '0;
                            col_reg     <= '0;
                            built_reg   <= 1'b0;
                            fin_reg     <= 1'b0;
                            m_valid_reg <= 1'b1;
                            q_valid_reg <= 1'b0;
                            done_reg    <= 1'b0;
                            f_axis_reg  <= '0;
                            f_pos_reg   <= 1'b0;
                            ox_reg      <= '0;
                            oy_reg      <= '0;
                            oz_reg      <= '0;
                            eu_reg      <= '0;
                            ev_reg      <= '0;
                            fmat_reg    <= '0;
                        end else if (fin_reg) begin
                            m_valid_reg <= 1'b1;
                            q_valid_reg <= 1'b0;
                            done_reg    <= 1'b1;
                            f_axis_reg  <= '0;
                            f_pos_reg   <= 1'b0;
                            ox_reg      <= '0;
                            oy_reg      <= '0;
                            oz_reg      <= '0;
                            eu_reg      <= '0;
                            ev_reg      <= '0;
                            fmat_reg    <= '0;
                        end else if (built_reg) begin
                            state_reg <= ST_SCAN;
                        end else begin
                            cnt_reg   <= '0;
                            state_reg <= ST_BLD_A;
                        end
                    end
                end
                ST_BLD_A: begin
                    state_reg <= ST_BLD_B;
                end
                ST_BLD_B: begin
                    cur_reg   <= cur_in ? vox_rdata : empty_reg;
                    state_reg <= ST_BLD_C;
                end
                ST_BLD_C: begin
                    cnt_reg <= cnt_reg + MSK_AW'(1);
                    if (cnt_reg == '1) begin
                        built_reg <= 1'b1;
                        row_reg   <= '0;
                        col_reg   <= '0;
                        state_reg <= ST_SCAN;
                    end else begin
                        state_reg <= ST_BLD_A;
                    end
                end
                ST_SCAN: begin
                    priority if (row_reg == EXT_C) begin
                        // Slice exhausted: move on to the next slice or axis, or end the scan after the last axis.
                        built_reg <= 1'b0;
                        cnt_reg   <= '0;
                        if (sl1_reg == EXT_C) begin
                            sl1_reg <= '0;
                            if (axis_reg == AXIS_Z) begin
                                axis_reg    <= AXIS_X;
                                fin_reg     <= 1'b1;
                                state_reg   <= ST_IDLE;
                                m_valid_reg <= 1'b1;
                                q_valid_reg <= 1'b0;
                                done_reg    <= 1'b1;
                                f_axis_reg  <= '0;
                                f_pos_reg   <= 1'b0;
                                ox_reg      <= '0;
                                oy_reg      <= '0;
                                oz_reg      <= '0;
                                eu_reg      <= '0;
                                ev_reg      <= '0;
                                fmat_reg    <= '0;
                            end else begin
                                axis_reg  <= axis_reg + 2'd1;
                                state_reg <= ST_BLD_A;
                            end
                        end else begin
                            sl1_reg   <= sl1_reg + CW1'(1);
                            state_reg <= ST_BLD_A;
                        end
                    end else if (col_reg == EXT_C) begin
                        row_reg <= row_reg + CW1'(1);
                        col_reg <= '0;
                    end else begin
                        state_reg <= ST_SCHK;
                    end
                end
                ST_SCHK: begin
                    if (msk_rdata[CELL_W-1:1] == empty_reg) begin
                        col_reg   <= col_reg + CW1'(1);
                        state_reg <= ST_SCAN;
                    end else begin
                        cmat_reg  <= msk_rdata[CELL_W-1:1];
                        cpos_reg  <= msk_rdata[0];
                        w_reg     <= CW1'(1);
                        state_reg <= ST_GU;
                    end
                end
                ST_GU: begin
                    if (uw_sum == EXT_S) begin
                        h_reg     <= CW1'(1);
                        state_reg <= ST_GV;
                    end else begin
                        state_reg <= ST_GU_CHK;
                    end
                end
                ST_GU_CHK: begin
                    if (cell_same) begin
                        w_reg     <= w_reg + CW1'(1);
                        state_reg <= ST_GU;
                    end else begin
                        h_reg     <= CW1'(1);
                        state_reg <= ST_GV;
                    end
                end
                ST_GV: begin
                    a_reg <= '0;
                    b_reg <= '0;
                    if (vh_sum == EXT_S) begin
                        state_reg <= ST_CLR;
                    end else begin
                        state_reg <= ST_GV_RD;
                    end
                end
                ST_GV_RD: begin
                    state_reg <= ST_GV_CHK;
                end
                ST_GV_CHK: begin
                    if (!cell_same) begin
                        a_reg     <= '0;
                        state_reg <= ST_CLR;
                    end else if (CW1'(a_reg) + CW1'(1) == w_reg) begin
                        h_reg     <= h_reg + CW1'(1);
                        state_reg <= ST_GV;
                    end else begin
                        a_reg     <= a_reg + CW'(1);
                        state_reg <= ST_GV_RD;
                    end
                end
                ST_CLR: begin
                    if (CW1'(a_reg) + CW1'(1) == w_reg) begin
                        a_reg <= '0;
                        b_reg <= b_reg + CW'(1);
                        if (CW1'(b_reg) + CW1'(1) == h_reg) begin
                            state_reg <= ST_OUT;
                        end
                    end else begin
                        a_reg <= a_reg + CW'(1);
                    end
                end
                ST_OUT: begin
                    m_valid_reg <= 1'b1;
                    q_valid_reg <= 1'b1;
                    done_reg    <= 1'b0;
                    f_axis_reg  <= axis_reg;
                    f_pos_reg   <= cpos_reg;
                    eu_reg      <= EXT_W'(w_reg);
                    ev_reg      <= EXT_W'(h_reg);
                    fmat_reg    <= MAT_IN_W'(cmat_reg);
                    unique case (axis_reg)
                        AXIS_X: begin
                            ox_reg <= ORG_W'(sl1_reg);
                            oy_reg <= ORG_W'(col_reg);
                            oz_reg <= ORG_W'(row_reg);
                        end
                        AXIS_Y: begin
                            oy_reg <= ORG_W'(sl1_reg);
                            oz_reg <= ORG_W'(col_reg);
                            ox_reg <= ORG_W'(row_reg);
                        end
                        default: begin
                            oz_reg <= ORG_W'(sl1_reg);
                            ox_reg <= ORG_W'(col_reg);
                            oy_reg <= ORG_W'(row_reg);
                        end
                    endcase
                    col_reg   <= uw_sum[CW1-1:0];
                    state_reg <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_quad_valid      = q_valid_reg;
    assign m_scan_done       = done_reg;
    assign m_face_axis       = f_axis_reg;
    assign m_normal_positive = f_pos_reg;
    assign m_origin_x        = ox_reg;
    assign m_origin_y        = oy_reg;
    assign m_origin_z        = oz_reg;
    assign m_extent_u        = eu_reg;
    assign m_extent_v        = ev_reg;
    assign m_face_material   = fmat_reg;
endmodule

// File: rtl/gvm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module gvm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// File: tb/sv/greedy_voxel_face_mesher_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for greedy_voxel_face_mesher: voxel writes and quad fetches
// are checked against a behavioral mesher kept in step with every accepted item.
// Depends on gvm_pkg and the mesher RTL.
module greedy_voxel_face_mesher_tb;
    import gvm_pkg::*;

    localparam int EXT = 16;

    typedef struct packed {
        logic        quad_valid;
        logic        scan_done;
        logic [1:0]  face_axis;
        logic        normal_positive;
        logic [4:0]  origin_x;
        logic [4:0]  origin_y;
        logic [4:0]  origin_z;
        logic [4:0]  extent_u;
        logic [4:0]  extent_v;
        logic [15:0] face_material;
    } quad_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_opcode = OP_WRITE;
    logic [3:0]  s_voxel_x = '0, s_voxel_y = '0, s_voxel_z = '0;
    logic [15:0] s_material = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_quad_valid, m_scan_done, m_normal_positive;
    logic [1:0]  m_face_axis;
    logic [4:0]  m_origin_x, m_origin_y, m_origin_z, m_extent_u, m_extent_v;
    logic [15:0] m_face_material;

    greedy_voxel_face_mesher u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_voxel_x(s_voxel_x), .s_voxel_y(s_voxel_y), .s_voxel_z(s_voxel_z),
        .s_material(s_material),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_quad_valid(m_quad_valid), .m_scan_done(m_scan_done),
        .m_face_axis(m_face_axis), .m_normal_positive(m_normal_positive),
        .m_origin_x(m_origin_x), .m_origin_y(m_origin_y), .m_origin_z(m_origin_z),
        .m_extent_u(m_extent_u), .m_extent_v(m_extent_v),
        .m_face_material(m_face_material)
    );

    always #5 aclk = ~aclk;

    // Behavioral mesher state.
    logic [15:0] chunk_mat [EXT*EXT*EXT];
    bit          vox_set [EXT*EXT*EXT];
    logic [15:0] face_mat [EXT*EXT];
    logic        face_pos [EXT*EXT];
    logic [15:0] air_code = '0;
    int          cur_axis, cur_slice, cur_row, cur_col;
    bit          face_mask_ready, scan_finished;

    quad_t expected_quads [$];
    int    error_count = 0;
    int    burst_left = 0;
    bit    bursty = 1'b0;
    bit    hold_req = 1'b0;
    int    hold_left = 0;

    function automatic void restart_scan();
        cur_axis = 0;
        cur_slice = -1;
        cur_row = 0;
        cur_col = 0;
        face_mask_ready = 0;
        scan_finished = 0;
    endfunction

    function automatic logic [15:0] voxel_at(int p [3]);
        for (int k = 0; k < 3; k++)
            if (p[k] < 0 || p[k] >= EXT) return air_code;
        return chunk_mat[p[0] + EXT * (p[1] + EXT * p[2])];
    endfunction

    function automatic void build_face_mask();
        int p [3];
        int q [3];
        logic [15:0] cur, adj;
        bit cs, as;
        for (int v = 0; v < EXT; v++) begin
            for (int u = 0; u < EXT; u++) begin
                p[cur_axis] = cur_slice;
                p[(cur_axis + 1) % 3] = u;
                p[(cur_axis + 2) % 3] = v;
                q = p;
                q[cur_axis] = cur_slice + 1;
                cur = voxel_at(p);
                adj = voxel_at(q);
                cs = (cur != air_code);
                as = (adj != air_code);
                face_mat[u + EXT * v] = air_code;
                face_pos[u + EXT * v] = 1'b0;
                if (cs != as) begin
                    face_mat[u + EXT * v] = cs ? cur : adj;
                    face_pos[u + EXT * v] = cs;
                end
            end
        end
    endfunction

    // True when every voxel of plane c on the given axis has been written, or when c lies outside the chunk.
    function automatic bit plane_set(int axis, int c);
        int p [3];
        if (c < 0 || c >= EXT) return 1'b1;
        for (int v = 0; v < EXT; v++)
            for (int u = 0; u < EXT; u++) begin
                p[axis] = c;
                p[(axis + 1) % 3] = u;
                p[(axis + 2) % 3] = v;
                if (!vox_set[p[0] + EXT * (p[1] + EXT * p[2])]) return 1'b0;
            end
        return 1'b1;
    endfunction

    function automatic bit slice_has_face(int axis, int s);
        int p [3];
        int q [3];
        for (int v = 0; v < EXT; v++)
            for (int u = 0; u < EXT; u++) begin
                p[axis] = s;
                p[(axis + 1) % 3] = u;
                p[(axis + 2) % 3] = v;
                q = p;
                q[axis] = s + 1;
                if ((voxel_at(p) != air_code) != (voxel_at(q) != air_code)) return 1'b1;
            end
        return 1'b0;
    endfunction

    // True when the next fetch only reads voxels that have been written. The
    // scan stops at the first slice with a face, so only the slices up to
    // that one are looked at.
    function automatic bit fetch_safe();
        int ax;
        int sl;
        if (scan_finished) return 1'b1;
        ax = cur_axis;
        sl = cur_slice;
        if (face_mask_ready) begin
            for (int i = 0; i < EXT * EXT; i++)
                if (face_mat[i] != air_code) return 1'b1;
            sl++;
        end
        while (ax < 3) begin
            if (sl >= EXT) begin
                sl = -1;
                ax++;
            end else if (!plane_set(ax, sl) || !plane_set(ax, sl + 1)) begin
                return 1'b0;
            end else if (slice_has_face(ax, sl)) begin
                return 1'b1;
            end else begin
                sl++;
            end
        end
        return 1'b1;
    endfunction

    function automatic quad_t next_quad();
        quad_t r;
        int org [3];
        int u, v, w, h, idx;
        bit grow;
        logic [15:0] cm;
        logic cp;
        r = '0;
        while (!scan_finished) begin
            if (!face_mask_ready) begin
                build_face_mask();
                face_mask_ready = 1;
                cur_row = 0;
                cur_col = 0;
            end
            while (cur_row < EXT) begin
                while (cur_col < EXT) begin
                    u = cur_col;
                    v = cur_row;
                    cm = face_mat[u + EXT * v];
                    cp = face_pos[u + EXT * v];
                    if (cm == air_code) begin
                        cur_col++;
                        continue;
                    end
                    w = 1;
                    h = 1;
                    grow = 1;
                    while (u + w < EXT && face_mat[u + w + EXT * v] == cm &&
                           face_pos[u + w + EXT * v] == cp)
                        w++;
                    while (v + h < EXT && grow) begin
                        for (int a = 0; a < w; a++) begin
                            idx = u + a + EXT * (v + h);
                            if (face_mat[idx] != cm || face_pos[idx] != cp) begin
                                grow = 0;
                                break;
                            end
                        end
                        if (grow) h++;
                    end
                    for (int b = 0; b < h; b++)
                        for (int a = 0; a < w; a++) begin
                            face_mat[u + a + EXT * (v + b)] = air_code;
                            face_pos[u + a + EXT * (v + b)] = 1'b0;
                        end
                    cur_col = u + w;
                    org[cur_axis] = cur_slice + 1;
                    org[(cur_axis + 1) % 3] = u;
                    org[(cur_axis + 2) % 3] = v;
                    r.quad_valid = 1'b1;
                    r.face_axis = cur_axis[1:0];
                    r.normal_positive = cp;
                    r.origin_x = org[0][4:0];
                    r.origin_y = org[1][4:0];
                    r.origin_z = org[2][4:0];
                    r.extent_u = w[4:0];
                    r.extent_v = h[4:0];
                    r.face_material = cm;
                    return r;
                end
                cur_row++;
                cur_col = 0;
            end
            face_mask_ready = 0;
            cur_slice++;
            if (cur_slice >= EXT) begin
                cur_slice = -1;
                cur_axis++;
                if (cur_axis >= 3) begin
                    cur_axis = 0;
                    scan_finished = 1;
                end
            end
        end
        r.scan_done = 1'b1;
        return r;
    endfunction

    function automatic quad_t predict_item(logic op, logic [3:0] x, logic [3:0] y,
                                           logic [3:0] z, logic [15:0] mat);
        if (op == OP_WRITE) begin
            chunk_mat[x + EXT * (y + EXT * z)] = mat;
            vox_set[x + EXT * (y + EXT * z)] = 1'b1;
            restart_scan();
            return '0;
        end
        return next_quad();
    endfunction

    // Sends one item, with a random gap first when the sender is bursting and its burst has run out.
    task automatic send_item(logic op, logic [3:0] x, logic [3:0] y, logic [3:0] z,
                             logic [15:0] mat, output quad_t predicted);
        int gap;
        if (bursty) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 8);
                burst_left = $urandom_range(1, 24);
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left--;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_opcode <= op;
        s_voxel_x <= x;
        s_voxel_y <= y;
        s_voxel_z <= z;
        s_material <= mat;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_item(op, x, y, z, mat);
        expected_quads.insert(expected_quads.size(), predicted);
    endtask

    task automatic write_voxel(int x, int y, int z, logic [15:0] mat);
        quad_t r;
        send_item(OP_WRITE, x[3:0], y[3:0], z[3:0], mat, r);
    endtask

    function automatic logic [15:0] pick_material();
        case ($urandom_range(0, 3))
            0: return air_code;
            1: return 16'(air_code + $urandom_range(1, 3));
            2: return 16'($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
            default: return 16'($urandom);
        endcase
    endfunction

    // A fetch is sent only when its scan reads written voxels alone; otherwise
    // a voxel of the two lowest x planes is written instead.
    task automatic fetch_quad(output quad_t r);
        if (fetch_safe())
            send_item(OP_FETCH, 4'($urandom), 4'($urandom), 4'($urandom), 16'($urandom), r);
        else
            send_item(OP_WRITE, 4'($urandom_range(0, 1)), 4'($urandom), 4'($urandom),
                      pick_material(), r);
    endtask

    // The sender stops and waits until every expected result has come back.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_quads.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_air_code(logic [15:0] code);
        drain();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= code;
        @(posedge aclk);
        air_code = code;
        restart_scan();
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Fills the two lowest x planes, which covers every voxel the first two
    // slices of the x axis read.
    task automatic fill_planes(int pct);
        for (int z = 0; z < EXT; z++)
            for (int y = 0; y < EXT; y++)
                for (int x = 0; x < 2; x++)
                    write_voxel(x, y, z, ($urandom_range(0, 99) < pct) ?
                                16'(air_code ^ (16'h1 << $urandom_range(0, 15))) : air_code);
    endtask

    task automatic fetch_run(int limit);
        quad_t r;
        for (int i = 0; i < limit; i++) begin
            if (!fetch_safe()) break;
            fetch_quad(r);
        end
    endtask

    task automatic test_write_extremes();
        write_voxel(0, 0, 0, 16'h0000);
        write_voxel(15, 15, 15, 16'hFFFF);
        write_voxel(15, 0, 15, 16'hA5A5);
        write_voxel(0, 15, 0, 16'h5A5A);
    endtask

    task automatic test_plane_scan();
        write_air_code(16'h0000);
        fill_planes(30);
        write_voxel(0, 0, 0, 16'hFFFF);
        write_voxel(1, 15, 15, 16'h0001);
        write_voxel(0, 8, 8, 16'h8000);
        write_voxel(0, 9, 8, 16'h8000);
        fetch_run(80);
    endtask

    // With the air code at its top value the material-0 voxels become solid.
    task automatic test_air_code_extreme();
        write_air_code(16'hFFFF);
        fetch_run(40);
        write_air_code(16'h0000);
    endtask

    task automatic test_restart_on_write();
        quad_t r;
        repeat (5) fetch_quad(r);
        write_voxel(0, 4, 5, 16'h0007);
        repeat (5) fetch_quad(r);
        write_air_code(16'h0003);
        repeat (5) fetch_quad(r);
        write_air_code(16'h0000);
        repeat (3) fetch_quad(r);
    endtask

    task automatic test_backpressure();
        quad_t r;
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++) begin
            if (i % 4 == 0) write_voxel($urandom_range(0, 15), $urandom_range(0, 15),
                                        $urandom_range(0, 15), pick_material());
            else fetch_quad(r);
        end
        drain();
    endtask

    task automatic test_random_traffic();
        quad_t r;
        int n;
        logic [15:0] codes [4];
        codes = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000};
        bursty = 1'b1;
        for (int phase = 0; phase < 4; phase++) begin
            write_air_code(codes[phase]);
            n = 0;
            while (n < 90) begin
                if ($urandom_range(0, 9) < 7) begin
                    repeat ($urandom_range(1, 6)) begin
                        write_voxel($urandom_range(0, 15), $urandom_range(0, 15),
                                    $urandom_range(0, 15), pick_material());
                        n++;
                    end
                    repeat ($urandom_range(1, 12)) begin
                        fetch_quad(r);
                        n++;
                    end
                end else begin
                    if ($urandom_range(0, 1) != 0)
                        fetch_quad(r);
                    else
                        send_item(OP_WRITE, 4'($urandom), 4'($urandom), 4'($urandom),
                                  16'($urandom), r);
                    n++;
                end
            end
        end
        bursty = 1'b0;
    endtask

    // Receiver: phases of steady acceptance and random stalls, plus a long hold on request.
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (($time / 640) % 3 == 1) begin
            m_ready <= ($urandom_range(0, 3) != 0);
        end else if (($time / 640) % 3 == 2) begin
            m_ready <= ($urandom_range(0, 1) != 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        quad_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_quads.size() == 0) begin
                $error("result with no pending item");
                error_count++;
            end else begin
                e = expected_quads.pop_front();
                check_field("quad_valid", e.quad_valid, m_quad_valid);
                check_field("scan_done", e.scan_done, m_scan_done);
                check_field("face_axis", e.face_axis, m_face_axis);
                check_field("normal_positive", e.normal_positive, m_normal_positive);
                check_field("origin_x", e.origin_x, m_origin_x);
                check_field("origin_y", e.origin_y, m_origin_y);
                check_field("origin_z", e.origin_z, m_origin_z);
                check_field("extent_u", e.extent_u, m_extent_u);
                check_field("extent_v", e.extent_v, m_extent_v);
                check_field("face_material", e.face_material, m_face_material);
            end
        end
    end

    initial begin
        for (int i = 0; i < EXT * EXT; i++) begin
            face_mat[i] = '0;
            face_pos[i] = 1'b0;
        end
        restart_scan();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_write_extremes();
        test_plane_scan();
        test_air_code_extreme();
        test_restart_on_write();
        test_backpressure();
        test_random_traffic();
        drain();
        repeat (20) @(posedge aclk);

        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
